[rtl/diff_drive_odometry_assert.svh]
// ---------------------------------------------------------------------------
// odometry assertion macros
// concurrent checks on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ODO_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// expression never true
`define ODO_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`else

`define ODO_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ODO_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

[rtl/odo_pkg.sv]
// ---------------------------------------------------------------------------
// odometry package
// shared types, constants and the arctangent table
// ---------------------------------------------------------------------------
package odo_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // divider dividend width, covers |dth| * 1e6
  localparam int DIV_W = 54;

  localparam logic [15:0] RADIUS_RESET = 16'd2163;
  localparam logic [15:0] SEP_RESET    = 16'd11141;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SEP    = 2'd1;

  localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
  localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
  localparam logic [DIV_W-1:0]   DTH_LIMIT   = DIV_W'(64'd8589934592);

  typedef struct packed {
    logic signed [31:0] dr;
    logic signed [31:0] dl;
    logic [31:0]        dt;
  } delta_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd843314857;
      5'd1:  v = 32'sd497837829;
      5'd2:  v = 32'sd263043837;
      5'd3:  v = 32'sd133525159;
      5'd4:  v = 32'sd67021687;
      5'd5:  v = 32'sd33543516;
      5'd6:  v = 32'sd16775851;
      5'd7:  v = 32'sd8388437;
      5'd8:  v = 32'sd4194283;
      5'd9:  v = 32'sd2097149;
      5'd10: v = 32'sd1048576;
      5'd11: v = 32'sd524288;
      5'd12: v = 32'sd262144;
      5'd13: v = 32'sd131072;
      5'd14: v = 32'sd65536;
      5'd15: v = 32'sd32768;
      5'd16: v = 32'sd16384;
      5'd17: v = 32'sd8192;
      5'd18: v = 32'sd4096;
      5'd19: v = 32'sd2048;
      5'd20: v = 32'sd1024;
      5'd21: v = 32'sd512;
      5'd22: v = 32'sd256;
      5'd23: v = 32'sd128;
      5'd24: v = 32'sd64;
      5'd25: v = 32'sd32;
      5'd26: v = 32'sd16;
      5'd27: v = 32'sd8;
      5'd28: v = 32'sd4;
      5'd29: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/odo_front.sv]
// ---------------------------------------------------------------------------
// odometry front end
// takes samples, forms wheel angle and time deltas, pushes them to the queue
// ---------------------------------------------------------------------------
module odo_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  right_angle,
  input  logic signed [31:0]  left_angle,
  input  logic [31:0]         stamp_us,
  input  odo_pkg::q_status_t  q_status,
  output logic                push,
  output odo_pkg::delta_t     item
);

  logic [31:0] last_right;
  logic [31:0] last_left;
  logic [31:0] last_stamp;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // wrap-around differences
  assign item.dr = $signed(right_angle - last_right);
  assign item.dl = $signed(left_angle - last_left);
  assign item.dt = stamp_us - last_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_right <= '0;
      last_left  <= '0;
      last_stamp <= '0;
    end else if (push) begin
      last_right <= right_angle;
      last_left  <= left_angle;
      last_stamp <= stamp_us;
    end
  end

endmodule

[rtl/odo_queue.sv]
// ---------------------------------------------------------------------------
// odometry delta queue
// short fifo between front end and back end
// ---------------------------------------------------------------------------
module odo_queue #(
  parameter int DEPTH = odo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  odo_pkg::delta_t    item_in,
  input  logic               pop,
  output odo_pkg::delta_t    item_out,
  output odo_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  odo_pkg::delta_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign item_out     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/odo_div.sv]
// ---------------------------------------------------------------------------
// odometry divider
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module odo_div (
  input  logic              clk,
  input  logic              rst,
  input  odo_pkg::div_req_t req,
  output odo_pkg::div_rsp_t rsp
);

  localparam int W  = odo_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [31:0]   rem;
  logic [31:0]   dsor;
  logic [CW-1:0] cnt;
  logic [32:0]   trial;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign ge    = (trial >= {1'b0, dsor});

  assign rsp.busy     = (cnt != '0);
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= CW'(W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dsor <= req.divisor;
    end else if (cnt != '0) begin
      quo <= {quo[W-2:0], ge};
      rem <= ge ? 32'(trial - {1'b0, dsor}) : trial[31:0];
    end
  end

endmodule

[rtl/odo_cordic.sv]
// ---------------------------------------------------------------------------
// odometry cordic
// reduces an angle modulo 2 pi, folds it, then rotates one step per cycle
// ---------------------------------------------------------------------------
module odo_cordic #(
  parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF,
  parameter int AW    = 46
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] angle,
  output logic                 busy,
  output logic signed [31:0]   cos_o,
  output logic signed [31:0]   sin_o
);

  localparam int NSTEP     = (STEPS < 30) ? STEPS : 30;
  localparam int IW        = $clog2(NSTEP);
  localparam int RED_STEPS = AW - 32;
  localparam int KW        = $clog2(RED_STEPS);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_RED  = 3'd1;
  localparam logic [2:0] C_FIX  = 3'd2;
  localparam logic [2:0] C_ITER = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  localparam logic signed [34:0] TWO_PI  = 35'(odo_pkg::TWO_PI_Q30);
  localparam logic signed [34:0] PI      = 35'(odo_pkg::PI_Q30);
  localparam logic signed [34:0] HALF_PI = 35'(odo_pkg::HALF_PI_Q30);

  logic [2:0]          state;
  logic [AW-1:0]       mag;
  logic                aneg;
  logic [KW-1:0]       kcnt;
  logic [IW-1:0]       step;
  logic signed [34:0]  r;
  logic signed [33:0]  x;
  logic signed [33:0]  y;
  logic                flip;

  logic [63:0]         sub;
  logic signed [34:0]  m35;
  logic signed [34:0]  r0;
  logic signed [34:0]  r1;
  logic signed [33:0]  xs;
  logic signed [33:0]  ys;
  logic signed [34:0]  at;

  assign busy = (state != C_IDLE);
  assign sub  = 64'(odo_pkg::TWO_PI_Q30) << kcnt;
  assign m35  = $signed({2'b00, mag[32:0]});
  assign r0   = (aneg && (m35 != '0)) ? TWO_PI - m35 : m35;
  assign r1   = (r0 >= PI) ? r0 - TWO_PI : r0;
  assign xs   = x >>> step;
  assign ys   = y >>> step;
  assign at   = 35'(odo_pkg::atan_q30(5'(step)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: if (start) state <= C_RED;
        C_RED:  if (kcnt == '0) state <= C_FIX;
        C_FIX:  state <= C_ITER;
        C_ITER: if (step == IW'(NSTEP - 1)) state <= C_FIN;
        C_FIN:  state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          aneg <= angle[AW-1];
          mag  <= angle[AW-1] ? AW'(-angle) : AW'(angle);
          kcnt <= KW'(RED_STEPS - 1);
        end
      end
      C_RED: begin
        // subtract the largest fitting multiple of 2 pi, one bit a cycle
        if (64'(mag) >= sub) begin
          mag <= mag - AW'(sub);
        end
        kcnt <= kcnt - 1'b1;
      end
      C_FIX: begin
        // fold into [-pi/2, pi/2], remember the sign flip
        if (r1 > HALF_PI) begin
          r    <= r1 - PI;
          flip <= 1'b1;
        end else if (r1 < -HALF_PI) begin
          r    <= r1 + PI;
          flip <= 1'b1;
        end else begin
          r    <= r1;
          flip <= 1'b0;
        end
        x    <= 34'(odo_pkg::GAIN_Q30);
        y    <= '0;
        step <= '0;
      end
      C_ITER: begin
        if (r >= 0) begin
          x <= x - ys;
          y <= y + xs;
          r <= r - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          r <= r + at;
        end
        step <= step + 1'b1;
      end
      C_FIN: begin
        cos_o <= flip ? 32'(-x) : 32'(x);
        sin_o <= flip ? 32'(-y) : 32'(y);
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/odo_back.sv]
// ---------------------------------------------------------------------------
// odometry back end
// sequencer for pose, velocity and quaternion, with the result register
// ---------------------------------------------------------------------------
module odo_back #(
  parameter int FRACTION_BITS = odo_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS  = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        radius,
  input  logic [15:0]        separation,
  input  odo_pkg::q_status_t q_status,
  input  odo_pkg::delta_t    item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] linear_vel,
  output logic signed [31:0] angular_vel,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic               zero_interval
);

  localparam int DW = odo_pkg::DIV_W;
  localparam int SH = 30 - FRACTION_BITS;
  localparam int AW = 32 + SH;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_DTH_GO   = 4'd2;
  localparam logic [3:0] S_DTH_WAIT = 4'd3;
  localparam logic [3:0] S_THETA    = 4'd4;
  localparam logic [3:0] S_CS1_GO   = 4'd5;
  localparam logic [3:0] S_CS1_WAIT = 4'd6;
  localparam logic [3:0] S_POS_MUL  = 4'd7;
  localparam logic [3:0] S_POS_ACC  = 4'd8;
  localparam logic [3:0] S_LIN_MUL  = 4'd9;
  localparam logic [3:0] S_LIN_GO   = 4'd10;
  localparam logic [3:0] S_LIN_WAIT = 4'd11;
  localparam logic [3:0] S_ANG_MUL  = 4'd12;
  localparam logic [3:0] S_ANG_GO   = 4'd13;
  localparam logic [3:0] S_ANG_WAIT = 4'd14;
  localparam logic [3:0] S_FIN      = 4'd15;

  localparam logic signed [20:0] US_PER_S = 21'sd1000000;

  logic [3:0]          state;
  logic signed [31:0]  dr;
  logic signed [31:0]  dl;
  logic [31:0]         dt;
  logic signed [49:0]  prod_s;
  logic signed [49:0]  prod_d;
  logic signed [31:0]  ds;
  logic signed [34:0]  dth;
  logic signed [55:0]  vprod;
  logic signed [63:0]  px;
  logic signed [63:0]  py;
  logic signed [31:0]  acc_x;
  logic signed [31:0]  acc_y;
  logic signed [31:0]  acc_theta;
  logic signed [31:0]  lin;
  logic signed [31:0]  ang;

  logic signed [32:0]  sum_w;
  logic signed [32:0]  dif_w;
  logic signed [16:0]  rad17;
  logic [15:0]         sep_eff;
  logic [49:0]         dmag;
  logic [55:0]         vmag;
  logic [DW-1:0]       dth_m;
  logic signed [AW-1:0] th_full;
  logic signed [AW-1:0] cs_angle;
  logic                cs_start;
  logic                cs_busy;
  logic signed [31:0]  cs_cos;
  logic signed [31:0]  cs_sin;
  logic                out_free;

  odo_pkg::div_req_t   div_req;
  odo_pkg::div_rsp_t   div_rsp;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // sign and magnitude quotient to saturated 32 bits
  function automatic logic signed [31:0] vel_sat(input logic neg, input logic [DW-1:0] q);
    if (!neg) begin
      if (q > DW'(32'h7fffffff)) return 32'sh7fffffff;
      return $signed(q[31:0]);
    end
    if (q >= DW'(33'h80000000)) return 32'sh80000000;
    return $signed(-q[31:0]);
  endfunction

  // round half up from q2.30 to q1.15
  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [17:0] q;
    t = 33'(v) + 33'sd16384;
    q = 18'(t >>> 15);
    if (q > 18'sd32767) return 16'sh7fff;
    if (q < -18'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  assign pop      = (state == S_IDLE) && !q_status.empty;
  assign sum_w    = 33'(dr) + 33'(dl);
  assign dif_w    = 33'(dr) - 33'(dl);
  assign rad17    = $signed({1'b0, radius});
  assign sep_eff  = (separation == '0) ? 16'd1 : separation;
  assign dmag     = prod_d[49] ? 50'(-prod_d) : 50'(prod_d);
  assign vmag     = vprod[55] ? 56'(-vprod) : 56'(vprod);
  assign dth_m    = (div_rsp.quotient > odo_pkg::DTH_LIMIT) ? odo_pkg::DTH_LIMIT
                                                            : div_rsp.quotient;
  assign th_full  = AW'(acc_theta) <<< SH;
  assign cs_start = (state == S_CS1_GO) || (state == S_POS_ACC);
  assign cs_angle = (state == S_POS_ACC) ? (th_full >>> 1) : th_full;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    div_req.start    = (state == S_DTH_GO) || (state == S_LIN_GO) || (state == S_ANG_GO);
    div_req.dividend = (state == S_DTH_GO) ? DW'(dmag) : DW'(vmag);
    div_req.divisor  = (state == S_DTH_GO) ? {16'd0, sep_eff} : dt;
  end

  odo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  odo_cordic #(
    .STEPS (CORDIC_STEPS),
    .AW    (AW)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cs_start),
    .angle (cs_angle),
    .busy  (cs_busy),
    .cos_o (cs_cos),
    .sin_o (cs_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc_x     <= '0;
      acc_y     <= '0;
      acc_theta <= '0;
    end else begin
      // load a new result, or drop valid once the held one is taken
      if ((state == S_FIN) && !cs_busy && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (!q_status.empty) state <= S_MUL;
        S_MUL: state <= S_DTH_GO;
        S_DTH_GO: state <= S_DTH_WAIT;
        S_DTH_WAIT: if (!div_rsp.busy) state <= S_THETA;
        S_THETA: begin
          acc_theta <= sat36(36'(acc_theta) + 36'(dth));
          state     <= S_CS1_GO;
        end
        S_CS1_GO: state <= S_CS1_WAIT;
        S_CS1_WAIT: if (!cs_busy) state <= S_POS_MUL;
        S_POS_MUL: state <= S_POS_ACC;
        S_POS_ACC: begin
          acc_x <= sat36(36'(acc_x) + 36'(px >>> 30));
          acc_y <= sat36(36'(acc_y) + 36'(py >>> 30));
          state <= S_LIN_MUL;
        end
        S_LIN_MUL: state <= (dt == '0) ? S_FIN : S_LIN_GO;
        S_LIN_GO: state <= S_LIN_WAIT;
        S_LIN_WAIT: if (!div_rsp.busy) state <= S_ANG_MUL;
        S_ANG_MUL: state <= S_ANG_GO;
        S_ANG_GO: state <= S_ANG_WAIT;
        S_ANG_WAIT: if (!div_rsp.busy) state <= S_FIN;
        S_FIN: if (!cs_busy && out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          dr <= item.dr;
          dl <= item.dl;
          dt <= item.dt;
        end
      end
      S_MUL: begin
        prod_s <= rad17 * sum_w;
        prod_d <= rad17 * dif_w;
      end
      S_DTH_GO: begin
        ds <= 32'(prod_s >>> 17);
      end
      S_DTH_WAIT: begin
        if (!div_rsp.busy) begin
          dth <= prod_d[49] ? -35'(dth_m) : 35'(dth_m);
        end
      end
      S_POS_MUL: begin
        px <= ds * cs_cos;
        py <= ds * cs_sin;
      end
      S_LIN_MUL: begin
        vprod <= ds * US_PER_S;
        lin   <= '0;
        ang   <= '0;
      end
      S_LIN_WAIT: begin
        if (!div_rsp.busy) begin
          lin <= vel_sat(vprod[55], div_rsp.quotient);
        end
      end
      S_ANG_MUL: begin
        vprod <= dth * US_PER_S;
      end
      S_ANG_WAIT: begin
        if (!div_rsp.busy) begin
          ang <= vel_sat(vprod[55], div_rsp.quotient);
        end
      end
      S_FIN: begin
        if (!cs_busy && out_free) begin
          pos_x         <= acc_x;
          pos_y         <= acc_y;
          heading       <= acc_theta;
          linear_vel    <= lin;
          angular_vel   <= ang;
          quat_z        <= to_q15(cs_sin);
          quat_w        <= to_q15(cs_cos);
          zero_interval <= (dt == '0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/diff_drive_odometry.sv]
// ---------------------------------------------------------------------------
// differential drive odometry
// pose, body velocity and heading quaternion from wheel angle samples
// ---------------------------------------------------------------------------
//
//  channel  handshake          payload
//  -------  -----------------  ----------------------------------------------
//  in       in_valid/in_stall  right_angle, left_angle, stamp_us
//  out      out_valid/out_stall pos_x, pos_y, heading, linear_vel,
//                              angular_vel, quat_z, quat_w, zero_interval
//  cfg      cfg_we             cfg_index, cfg_data (write only)
//
//  one result per sample, in order; angle reduction takes 14 steps at defaults,
//  rotation CORDIC_STEPS; the heading divide and both velocity divides use the
//  shared one-bit-per-cycle divider; a zero interval skips both velocity divides
//  the front end and the delta queue take new samples while the back end works
//  synchronous reset clears wheel history and pose, config registers to defaults
//  a stalled output holds its result; the back end waits only to load it
//
module diff_drive_odometry #(
  parameter int CORDIC_STEPS  = odo_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = odo_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = odo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // sample input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] right_angle,
  input  logic signed [31:0] left_angle,
  input  logic [31:0]        stamp_us,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] linear_vel,
  output logic signed [31:0] angular_vel,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic               zero_interval,
  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration registers
  logic [15:0] radius_cfg;
  logic [15:0] sep_cfg;

  // front to queue, queue to back
  logic               push;
  logic               pop;
  odo_pkg::delta_t    front_item;
  odo_pkg::delta_t    back_item;
  odo_pkg::q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_cfg <= odo_pkg::RADIUS_RESET;
      sep_cfg    <= odo_pkg::SEP_RESET;
    end else if (cfg_we) begin
      // writes to unknown indexes are dropped
      unique case (cfg_index)
        odo_pkg::REG_RADIUS: radius_cfg <= cfg_data;
        odo_pkg::REG_SEP:    sep_cfg    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // wheel and time deltas, last sample history
  odo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .right_angle (right_angle),
    .left_angle  (left_angle),
    .stamp_us    (stamp_us),
    .q_status    (q_status),
    .push        (push),
    .item        (front_item)
  );

  // decouples sample transfer from the long back-end sequence
  odo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (front_item),
    .pop      (pop),
    .item_out (back_item),
    .status   (q_status)
  );

  // arc length, heading, cordic pose update, velocity divides
  odo_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .radius        (radius_cfg),
    .separation    (sep_cfg),
    .q_status      (q_status),
    .item          (back_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .linear_vel    (linear_vel),
    .angular_vel   (angular_vel),
    .quat_z        (quat_z),
    .quat_w        (quat_w),
    .zero_interval (zero_interval)
  );

`include "diff_drive_odometry_assert.svh"

  // velocities are forced to zero on a zero interval
  `ODO_ASSERT_IMPLIES(a_zero_vel, out_valid && zero_interval, linear_vel == 0 && angular_vel == 0, "zero interval with nonzero velocity")
  // a unit quaternion never has both components at zero
  `ODO_ASSERT_NEVER(a_quat_nonzero, out_valid && quat_z == 0 && quat_w == 0, "degenerate quaternion")
  // queue cannot report full and empty together
  `ODO_ASSERT_NEVER(a_queue_state, q_status.full && q_status.empty, "queue full and empty")

endmodule

[tb/sv/odo_checker.sv]
// ---------------------------------------------------------------------------
// odometry checker
// watches the sample, result and config ports, predicts each pose update
// and compares every result transfer field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module odo_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] right_angle,
  input  logic signed [31:0] left_angle,
  input  logic [31:0]        stamp_us,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic signed [31:0] linear_vel,
  input  logic signed [31:0] angular_vel,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic               zero_interval,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fails,
  output int                 pending
);

  localparam int STEPS = 16;
  localparam longint TWO_PI  = 64'sd6746518852;
  localparam longint PI      = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN    = 64'sd652032874;
  localparam longint DTH_MAX = 64'sd8589934592;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] th;
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               zi;
  } pose_t;

  longint atan_tab [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  pose_t pose_q [$];

  logic [15:0]        radius, separation;
  logic [31:0]        prev_r, prev_l, prev_t;
  logic signed [31:0] acc_x, acc_y, acc_th;

  assign pending = pose_q.size();

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input longint v);
    longint q;
    q = (v + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // rotate the gain vector by ang (q34.30), folded into +-pi/2 first
  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint r, x, y, nx;
    bit     flip;
    r = ang % TWO_PI;
    x = GAIN;
    y = 0;
    flip = 0;
    if (r < 0) r += TWO_PI;
    if (r >= PI) r -= TWO_PI;
    if (r > HALF_PI) begin
      r -= PI;
      flip = 1;
    end else if (r < -HALF_PI) begin
      r += PI;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r += atan_tab[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic predict_pose(input logic [31:0] r_in, input logic [31:0] l_in,
                              input logic [31:0] t_in, output pose_t p);
    logic [31:0] d32r, d32l, dt;
    longint dr, dl, dtl, rad, sep, ds, dth, thq, c, s;
    d32r = r_in - prev_r;
    d32l = l_in - prev_l;
    dt   = t_in - prev_t;
    dr   = $signed(d32r);
    dl   = $signed(d32l);
    dtl  = dt;
    rad  = radius;
    sep  = (separation == 0) ? 1 : separation;
    prev_r = r_in;
    prev_l = l_in;
    prev_t = t_in;
    ds  = (rad * (dr + dl)) >>> 17;
    dth = (rad * (dr - dl)) / sep;
    if (dth > DTH_MAX) dth = DTH_MAX;
    if (dth < -DTH_MAX) dth = -DTH_MAX;
    p.lin = 0;
    p.ang = 0;
    if (dt != 0) begin
      p.lin = sat32((ds * 1000000) / dtl);
      p.ang = sat32((dth * 1000000) / dtl);
    end
    acc_th = sat32(longint'(acc_th) + dth);
    thq = longint'(acc_th) * 16384;
    sin_cos(thq, c, s);
    acc_x = sat32(longint'(acc_x) + ((ds * c) >>> 30));
    acc_y = sat32(longint'(acc_y) + ((ds * s) >>> 30));
    p.x  = acc_x;
    p.y  = acc_y;
    p.th = acc_th;
    sin_cos(thq >>> 1, c, s);
    p.qz = to_q15(s);
    p.qw = to_q15(c);
    p.zi = (dt == 0);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    pose_t want;
    pose_t p;
    if (rst) begin
      radius     <= odo_pkg::RADIUS_RESET;
      separation <= odo_pkg::SEP_RESET;
      prev_r = 0;
      prev_l = 0;
      prev_t = 0;
      acc_x  = 0;
      acc_y  = 0;
      acc_th = 0;
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == odo_pkg::REG_RADIUS) radius <= cfg_data;
        if (cfg_index == odo_pkg::REG_SEP) separation <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = pose_q.pop_front();
          if (pos_x !== want.x) report("pos_x", pos_x, want.x);
          if (pos_y !== want.y) report("pos_y", pos_y, want.y);
          if (heading !== want.th) report("heading", heading, want.th);
          if (linear_vel !== want.lin) report("linear_vel", linear_vel, want.lin);
          if (angular_vel !== want.ang) report("angular_vel", angular_vel, want.ang);
          if (quat_z !== want.qz) report("quat_z", quat_z, want.qz);
          if (quat_w !== want.qw) report("quat_w", quat_w, want.qw);
          if (zero_interval !== want.zi) report("zero_interval", zero_interval, want.zi);
        end
      end
      if (in_valid && !in_stall) begin
        predict_pose(right_angle, left_angle, stamp_us, p);
        pose_q = {pose_q, p};
      end
    end
  end

endmodule

[tb/sv/tb_diff_drive_odometry.sv]
// ---------------------------------------------------------------------------
// odometry testbench
// directed corner samples then random wheel trajectories over several
// radius and separation settings, with random idling on both channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_diff_drive_odometry;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PHASE_ITEMS    = 205;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] right_angle;
  logic signed [31:0] left_angle;
  logic [31:0]        stamp_us;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] pos_x, pos_y, heading, linear_vel, angular_vel;
  logic signed [15:0] quat_z, quat_w;
  logic               zero_interval;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  int  fails;
  int  pending;
  int  idle_cycles;
  bit  quiet;          // long stretch with no idling on either side
  logic [31:0] cur_r, cur_l, cur_t;

  diff_drive_odometry dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .right_angle(right_angle), .left_angle(left_angle), .stamp_us(stamp_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .linear_vel(linear_vel), .angular_vel(angular_vel),
    .quat_z(quat_z), .quat_w(quat_w), .zero_interval(zero_interval),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  odo_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .right_angle(right_angle), .left_angle(left_angle), .stamp_us(stamp_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .linear_vel(linear_vel), .angular_vel(angular_vel),
    .quat_z(quat_z), .quat_w(quat_w), .zero_interval(zero_interval),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver side: random stalls with an 8 percent chance, never during the quiet stretch
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= !quiet && ($urandom_range(0, 99) < 8);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending);
        $display("tb_diff_drive_odometry NOT OK");
        $finish;
      end
    end
  end

  // one sample transfer; valid stays high unless the sender idles afterward
  task automatic send_sample(input logic [31:0] r, input logic [31:0] l,
                             input logic [31:0] t);
    in_valid    <= 1;
    right_angle <= r;
    left_angle  <= l;
    stamp_us    <= t;
    cur_r = r;
    cur_l = l;
    cur_t = t;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // config writes only once the block has drained
  task automatic settle;
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 0;
  endtask

  // mostly smooth trajectories, some zero intervals, some raw noise
  task automatic random_phase(input int n);
    int k;
    logic [31:0] dr, dl, dt;
    for (k = 0; k < n; k++) begin
      quiet = (k >= 60 && k < 120);
      if ($urandom_range(0, 99) < 10) begin
        send_sample($urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: dr = $urandom_range(0, 131072) - 65536;
          1: dr = $urandom_range(0, 8388608) - 4194304;
          default: dr = $urandom_range(0, 16384) - 8192;
        endcase
        dl = ($urandom_range(0, 1)) ? dr + $urandom_range(0, 4096) - 2048
                                    : $urandom_range(0, 131072) - 65536;
        dt = ($urandom_range(0, 99) < 4) ? 32'd0 : $urandom_range(1, 50000);
        send_sample(cur_r + dr, cur_l + dl, cur_t + dt);
      end
    end
    quiet = 0;
  endtask

  initial begin
    rst         = 1;
    in_valid    = 0;
    right_angle = 0;
    left_angle  = 0;
    stamp_us    = 0;
    cfg_we      = 0;
    cfg_index   = odo_pkg::REG_RADIUS;
    cfg_data    = 0;
    quiet       = 0;
    cur_r = 0;
    cur_l = 0;
    cur_t = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero interval from time zero, extremes, wraps
    send_sample(32'd0, 32'd0, 32'd0);
    send_sample(32'h7fffffff, 32'h7fffffff, 32'd1000);
    send_sample(32'h80000000, 32'h80000000, 32'd2000);
    send_sample(32'h80000000, 32'h7fffffff, 32'd2000);
    send_sample(32'h7fffffff, 32'h80000000, 32'hffffff00);
    send_sample(32'h00010000, 32'hffff0000, 32'h00000100);   // time wrap
    send_sample(32'hffff8000, 32'h00008000, 32'hffffffff);
    send_sample(32'h00008000, 32'hffff8000, 32'h00000000);   // angle wrap
    send_sample(32'h00008000, 32'hffff8000, 32'h00000001);

    // pause until every result is back
    settle();
    // huge heading change: radius at max, separation zero
    write_reg(odo_pkg::REG_RADIUS, 16'hffff);
    write_reg(odo_pkg::REG_SEP, 16'h0000);
    send_sample(32'h7fffffff, 32'h80000000, 32'd5);
    send_sample(32'h80000000, 32'h7fffffff, 32'd5);
    send_sample(32'h7fffffff, 32'h80000000, 32'd6);
    // keep pushing heading and position toward saturation
    for (int i = 0; i < 8; i++)
      send_sample(cur_r + 32'h7fff0000, cur_l + 32'h7fff0000, cur_t + 1);
    send_sample(cur_r, cur_l, cur_t);
    random_phase(PHASE_ITEMS);

    settle();
    write_reg(odo_pkg::REG_RADIUS, 16'd1);
    write_reg(odo_pkg::REG_SEP, 16'hffff);
    random_phase(PHASE_ITEMS);

    settle();
    write_reg(odo_pkg::REG_RADIUS, odo_pkg::RADIUS_RESET);
    write_reg(odo_pkg::REG_SEP, odo_pkg::SEP_RESET);
    random_phase(PHASE_ITEMS);

    settle();
    write_reg(odo_pkg::REG_RADIUS, 16'hffff);
    write_reg(odo_pkg::REG_SEP, 16'd1);
    random_phase(PHASE_ITEMS);

    settle();
    write_reg(odo_pkg::REG_RADIUS, 16'($urandom_range(1, 65535)));
    write_reg(odo_pkg::REG_SEP, 16'($urandom_range(1, 65535)));
    random_phase(PHASE_ITEMS);

    settle();
    if (fails == 0 && pending == 0) begin
      $display("tb_diff_drive_odometry OK");
    end else begin
      $display("tb_diff_drive_odometry NOT OK");
    end
    $finish;
  end

endmodule
